// ===== sv/cqdp_pkg.sv =====
// shared types and constants for the crossbar quantized dot product unit
// no dependencies
`default_nettype none

package cqdp_pkg;

   localparam int ACT_W    = 16;
   localparam int OFS_W    = 32;
   localparam int PROD_W   = 2 * ACT_W;
   localparam int TERM_W   = OFS_W + 1;
   localparam int PSUM_W   = 40;
   localparam int TOTAL_W  = 14;
   localparam int CNT_W    = 9;
   localparam int QNT_W    = CNT_W + 1;
   localparam int MAX_ACCUM = 256;

   localparam int IN_DATA_W  = 2 * ACT_W + 2 * OFS_W;
   localparam int OUT_DATA_W = ((TOTAL_W + 7) / 8) * 8;

   typedef logic signed [PSUM_W-1:0]  psum_type;
   typedef logic signed [TOTAL_W-1:0] total_type;
   typedef logic signed [QNT_W-1:0]   qnt_type;
   typedef logic        [CNT_W-1:0]   cnt_type;

   localparam psum_type  PSUM_MAX  = {1'b0, {(PSUM_W-1){1'b1}}};
   localparam psum_type  PSUM_MIN  = {1'b1, {(PSUM_W-1){1'b0}}};
   localparam total_type TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
   localparam total_type TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== sv/cqdp_quantize.sv =====
// quantizer for one completed partial sum: sign for a group of one,
// otherwise even rounding with a clamp at the group size; uses cqdp_pkg
`default_nettype none

module cqdp_quantize (
   input  wire cqdp_pkg::psum_type psum,
   input  wire cqdp_pkg::cnt_type  group_n,
   output cqdp_pkg::qnt_type       quant
);

   logic                                 neg;
   logic [cqdp_pkg::PSUM_W-1:0]          mag;
   logic [cqdp_pkg::PSUM_W:0]            rnd;
   logic [cqdp_pkg::PSUM_W-16:0]         dbl;
   logic [cqdp_pkg::CNT_W-1:0]           mag_q;

   always_comb begin
      neg = psum[cqdp_pkg::PSUM_W-1];
      mag = neg ? (~psum + 1'b1) : psum;
      rnd = {1'b0, mag} + (cqdp_pkg::PSUM_W+1)'(65536);
      dbl = {rnd[cqdp_pkg::PSUM_W:17], 1'b0};
      if (dbl > (cqdp_pkg::PSUM_W-15)'(group_n)) begin
         mag_q = group_n;
      end else begin
         mag_q = dbl[cqdp_pkg::CNT_W-1:0];
      end
      if (group_n == cqdp_pkg::CNT_W'(1)) begin
         quant = neg ? -cqdp_pkg::QNT_W'(1) : cqdp_pkg::QNT_W'(1);
      end else if (neg) begin
         quant = -$signed({1'b0, mag_q});
      end else begin
         quant = $signed({1'b0, mag_q});
      end
   end

endmodule

`default_nettype wire

// ===== sv/crossbar_quantized_dot_product_unit.sv =====
// top level of the crossbar quantized dot product unit: elastic pipeline,
// group accumulation and row totals; uses cqdp_pkg and cqdp_quantize
`default_nettype none

// Takes one element pair per beat at a sustained rate of one beat per clock
// while the result side is not stalled, and emits one result beat for each
// beat flagged tlast. The rate is set by the two accumulation loops (group
// partial sum and row total); a stalled result stage only stops input once
// the five internal stages are full.
module crossbar_quantized_dot_product_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_we,
   input  wire [cqdp_pkg::CNT_W-1:0]          csr_wdata,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // activation, weight_value, var_plus, var_minus
   input  wire [cqdp_pkg::IN_DATA_W-1:0]      req_tdata,
   input  wire                                req_tlast,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // output_sum, zero padding
   output logic [cqdp_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   // length_error
   output logic                               rsp_tuser
);

   localparam int AW = cqdp_pkg::ACT_W;
   localparam int OW = cqdp_pkg::OFS_W;

   cqdp_pkg::cnt_type accum_n_ff;
   cqdp_pkg::cnt_type group_n;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, out_v_ff;
   logic r1, r2, r3, r4, r5, out_rdy;

   logic signed [AW-1:0]   act1_ff, wgt1_ff;
   logic signed [OW-1:0]   vp1_ff, vm1_ff, vp2_ff, vm2_ff;
   logic                   last1_ff, last2_ff, last3_ff, last4_ff, last5_ff;
   logic signed [cqdp_pkg::PROD_W-1:0] prod2_ff;
   logic signed [cqdp_pkg::TERM_W-1:0] term3_ff, term_in;

   cqdp_pkg::psum_type     psum_ff, psum_in, closed4_ff;
   logic signed [cqdp_pkg::PSUM_W:0] psum_wide;
   cqdp_pkg::cnt_type      count_ff, count_inc;
   logic                   close_in, err_in;
   logic                   close4_ff, err4_ff, close5_ff, err5_ff;
   cqdp_pkg::qnt_type      quant, quant5_ff;

   cqdp_pkg::total_type    row_ff, row_in;
   logic signed [cqdp_pkg::TOTAL_W:0] row_wide;
   cqdp_pkg::total_type    out_sum_ff;
   logic                   out_err_ff;

   // configuration register and effective group size
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_n_ff <= cqdp_pkg::CNT_W'(1);
      end else if (csr_we) begin
         accum_n_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (accum_n_ff == '0) begin
         group_n = cqdp_pkg::CNT_W'(1);
      end else if (accum_n_ff > cqdp_pkg::CNT_W'(cqdp_pkg::MAX_ACCUM)) begin
         group_n = cqdp_pkg::CNT_W'(cqdp_pkg::MAX_ACCUM);
      end else begin
         group_n = accum_n_ff;
      end
   end

   // ready chain, non-last beats retire from the last stage without output
   assign out_rdy    = !out_v_ff || rsp_tready;
   assign r5         = !v5_ff || !last5_ff || out_rdy;
   assign r4         = !v4_ff || r5;
   assign r3         = !v3_ff || r4;
   assign r2         = !v2_ff || r3;
   assign r1         = !v1_ff || r2;
   assign req_tready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= req_tvalid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
         if (r5) v5_ff <= v4_ff;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (r1) begin
         act1_ff  <= req_tdata[AW-1:0];
         wgt1_ff  <= req_tdata[2*AW-1:AW];
         vp1_ff   <= req_tdata[2*AW+OW-1:2*AW];
         vm1_ff   <= req_tdata[2*AW+2*OW-1:2*AW+OW];
         last1_ff <= req_tlast;
      end
   end

   // product, already at 16 fraction bits
   always_ff @(posedge clock) begin
      if (r2) begin
         prod2_ff <= act1_ff * wgt1_ff;
         vp2_ff   <= vp1_ff;
         vm2_ff   <= vm1_ff;
         last2_ff <= last1_ff;
      end
   end

   // offset by product sign
   always_comb begin
      if (prod2_ff > 0) begin
         term_in = cqdp_pkg::TERM_W'(prod2_ff) + cqdp_pkg::TERM_W'(vp2_ff);
      end else begin
         term_in = cqdp_pkg::TERM_W'(prod2_ff) + cqdp_pkg::TERM_W'(vm2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (r3) begin
         term3_ff <= term_in;
         last3_ff <= last2_ff;
      end
   end

   // group accumulation
   always_comb begin
      psum_wide = (cqdp_pkg::PSUM_W+1)'(psum_ff) + (cqdp_pkg::PSUM_W+1)'(term3_ff);
      if (psum_wide[cqdp_pkg::PSUM_W] != psum_wide[cqdp_pkg::PSUM_W-1]) begin
         psum_in = psum_wide[cqdp_pkg::PSUM_W] ? cqdp_pkg::PSUM_MIN : cqdp_pkg::PSUM_MAX;
      end else begin
         psum_in = psum_wide[cqdp_pkg::PSUM_W-1:0];
      end
      count_inc = count_ff + 1'b1;
      close_in  = (count_inc >= group_n) || last3_ff;
      err_in    = count_inc < group_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         psum_ff  <= '0;
         count_ff <= '0;
      end else if (v3_ff && r4) begin
         if (close_in) begin
            psum_ff  <= '0;
            count_ff <= '0;
         end else begin
            psum_ff  <= psum_in;
            count_ff <= count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (r4) begin
         closed4_ff <= psum_in;
         close4_ff  <= close_in;
         err4_ff    <= err_in;
         last4_ff   <= last3_ff;
      end
   end

   cqdp_quantize u_quantize (
      .psum    (closed4_ff),
      .group_n (group_n),
      .quant   (quant)
   );

   always_ff @(posedge clock) begin
      if (r5) begin
         quant5_ff <= quant;
         close5_ff <= close4_ff;
         err5_ff   <= err4_ff;
         last5_ff  <= last4_ff;
      end
   end

   // row total
   always_comb begin
      row_wide = (cqdp_pkg::TOTAL_W+1)'(row_ff) + (cqdp_pkg::TOTAL_W+1)'(quant5_ff);
      if (!close5_ff) begin
         row_in = row_ff;
      end else if (row_wide[cqdp_pkg::TOTAL_W] != row_wide[cqdp_pkg::TOTAL_W-1]) begin
         row_in = row_wide[cqdp_pkg::TOTAL_W] ? cqdp_pkg::TOTAL_MIN : cqdp_pkg::TOTAL_MAX;
      end else begin
         row_in = row_wide[cqdp_pkg::TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else if (v5_ff && r5) begin
         row_ff <= last5_ff ? '0 : row_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (v5_ff && last5_ff && out_rdy) begin
         out_v_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (v5_ff && last5_ff && out_rdy) begin
         out_sum_ff <= row_in;
         out_err_ff <= err5_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = cqdp_pkg::OUT_DATA_W'($unsigned(out_sum_ff));
   assign rsp_tuser  = out_err_ff;

endmodule

`default_nettype wire

// ===== sv/cqdp_checker.sv =====
// port-level checks for crossbar_quantized_dot_product_unit and their bind
// depends on cqdp_pkg and the top level
`default_nettype none

module cqdp_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_tready,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [cqdp_pkg::OUT_DATA_W-1:0]     rsp_tdata,
   input wire                                rsp_tuser
);

   // result beat cleared by reset
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // with no result waiting the pipeline drains, so input is open
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result stage");

   // stalled result beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // padding above the row total stays zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[cqdp_pkg::OUT_DATA_W-1:cqdp_pkg::TOTAL_W] == '0)
      else $error("result padding bits set");

endmodule

bind crossbar_quantized_dot_product_unit cqdp_checker u_cqdp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
